[hw/rtl/bco_pkg.sv]
// Package for the box count occupancy block: shared constants and control structs.
package bco_pkg;

    localparam int GRID_BITS_DEF   = 5;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int SCALE_W         = 32;
    localparam int COUNT_W         = 16;
    localparam int CHUNK_W         = 16;
    localparam int ROW_W           = 32;
    localparam int ROW_SEL_W       = 5;

    localparam logic [SCALE_W-1:0] INV_SCALE_RESET = 32'd65536;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic mac;
        logic axis_store;
        logic mem_rd;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic chunk_last;
        logic axis_last;
        logic out_free;
    } status_t;

endpackage

[hw/rtl/bco_ctrl.sv]
// Controller state machine: clear sweep, per-axis multiply sequencing, bitmap update.
module bco_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_start_req,
    output logic               s_ready,
    input  bco_pkg::status_t   sts,
    output bco_pkg::cmd_t      cmd
);
    import bco_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_AXIS  = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       pend_reg, pend_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        pend_next  = pend_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = pend_reg ? S_MUL : S_IDLE;
                    pend_next  = 1'b0;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_start_req) begin
                        state_next = S_CLEAR;
                        pend_next  = 1'b1;
                    end else begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL: begin
                cmd.mac = 1'b1;
                if (sts.chunk_last) begin
                    state_next = S_AXIS;
                end
            end
            S_AXIS: begin
                cmd.axis_store = 1'b1;
                state_next = sts.axis_last ? S_READ : S_MUL;
            end
            S_READ: begin
                cmd.mem_rd = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
                pend_next  = 1'b0;
            end
        endcase
    end

endmodule

[hw/rtl/bco_dp.sv]
// Datapath: scale register, shared multiply-accumulate, occupancy bitmap, count and result word.
module bco_dp #(
    parameter int GRID_BITS   = bco_pkg::GRID_BITS_DEF,
    parameter int COORD_WIDTH = bco_pkg::COORD_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  bco_pkg::cmd_t                    cmd,
    output bco_pkg::status_t                 sts,
    input  logic                             cfg_valid,
    input  logic [bco_pkg::SCALE_W-1:0]      cfg_inv_scale,
    input  logic signed [COORD_WIDTH-1:0]    s_x_coord,
    input  logic signed [COORD_WIDTH-1:0]    s_y_coord,
    input  logic signed [COORD_WIDTH-1:0]    s_z_coord,
    input  logic                             s_start_req,
    input  logic                             s_last,
    input  logic                             m_ready,
    output logic                             m_valid,
    output logic [bco_pkg::COUNT_W-1:0]      m_box_count,
    output logic                             m_new_box,
    output logic                             m_out_of_grid,
    output logic                             m_done_res
);
    import bco_pkg::*;

    localparam int CELL_BITS = 3 * GRID_BITS;
    localparam int ADDR_BITS = CELL_BITS - ROW_SEL_W;
    localparam int ROWS      = 1 << ADDR_BITS;
    localparam int CH        = (COORD_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int PW        = CH * CHUNK_W;
    localparam int AW        = PW + SCALE_W;
    localparam int CCW       = (CH > 1) ? $clog2(CH) : 1;
    localparam int MW        = CHUNK_W + SCALE_W;

    logic [SCALE_W-1:0]     inv_scale_reg;
    logic [COORD_WIDTH-1:0] x_reg, y_reg, z_reg;
    logic                   last_reg;
    logic [AW-1:0]          acc_reg;
    logic [CCW-1:0]         chunk_reg;
    logic [1:0]             axis_reg;
    logic [GRID_BITS-1:0]   idx_reg [0:2];
    logic [2:0]             oog_reg;
    logic [ADDR_BITS-1:0]   clr_addr_reg;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [ROW_W-1:0]       rd_data_reg;
    logic                   m_valid_reg;
    logic [COUNT_W-1:0]     m_box_count_reg;
    logic                   m_new_box_reg, m_out_of_grid_reg, m_done_res_reg;

    logic [ROW_W-1:0]       mem [0:ROWS-1];

    logic [COORD_WIDTH-1:0] coord_sel;
    logic [PW-1:0]          coord_pad;
    logic [CCW-1:0]         chunk_pos;
    logic [CHUNK_W-1:0]     chunk_val;
    logic [MW-1:0]          mul_w;
    logic [AW-1:0]          acc_base;
    logic [GRID_BITS-1:0]   a_idx;
    logic                   a_oog;
    logic [CELL_BITS-1:0]   box_addr;
    logic [ADDR_BITS-1:0]   row;
    logic [ROW_SEL_W-1:0]   bit_pos;
    logic                   is_new;
    logic                   mem_we;
    logic [ADDR_BITS-1:0]   mem_waddr;
    logic [ROW_W-1:0]       mem_wdata;

    always_comb begin
        case (axis_reg)
            AXIS_X:  coord_sel = x_reg;
            AXIS_Y:  coord_sel = y_reg;
            default: coord_sel = z_reg;
        endcase
    end

    // chunks go most significant first: acc = acc * 2^16 + chunk * scale
    assign coord_pad = PW'(coord_sel);
    assign chunk_pos = CCW'(CH - 1) - chunk_reg;
    assign chunk_val = CHUNK_W'(coord_pad >> {chunk_pos, 4'b0000});
    assign mul_w     = MW'(chunk_val) * MW'(inv_scale_reg);
    assign acc_base  = (chunk_reg == '0) ? '0
                     : {acc_reg[AW-CHUNK_W-1:0], {CHUNK_W{1'b0}}};

    assign a_idx = acc_reg[SCALE_W+GRID_BITS-1:SCALE_W];
    assign a_oog = (|acc_reg[AW-1:SCALE_W+GRID_BITS])
                 | (coord_sel[COORD_WIDTH-1] & (|inv_scale_reg));

    assign box_addr = {idx_reg[0], idx_reg[1], idx_reg[2]};
    assign row      = box_addr[CELL_BITS-1:ROW_SEL_W];
    assign bit_pos  = box_addr[ROW_SEL_W-1:0];
    assign is_new   = !(|oog_reg) && !rd_data_reg[bit_pos];

    assign mem_we    = cmd.clr_step | (cmd.commit & is_new);
    assign mem_waddr = cmd.clr_step ? clr_addr_reg : row;
    assign mem_wdata = cmd.clr_step ? '0
                     : (rd_data_reg | (ROW_W'(1) << bit_pos));

    always_comb begin
        count_next = count_reg;
        if (cmd.load && s_start_req) begin
            count_next = '0;
        end else if (cmd.commit && is_new && (count_reg != '1)) begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    assign sts.clr_last   = (clr_addr_reg == '1);
    assign sts.chunk_last = (chunk_reg == CCW'(CH - 1));
    assign sts.axis_last  = (axis_reg == AXIS_Z);
    assign sts.out_free   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_rd) begin
            rd_data_reg <= mem[row];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_scale_reg <= INV_SCALE_RESET;
            clr_addr_reg  <= '0;
            count_reg     <= '0;
            chunk_reg     <= '0;
            axis_reg      <= AXIS_X;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                inv_scale_reg <= cfg_inv_scale;
            end
            if (cmd.clr_step) begin
                clr_addr_reg <= clr_addr_reg + ADDR_BITS'(1);
            end
            count_reg <= count_next;
            if (cmd.load) begin
                chunk_reg <= '0;
                axis_reg  <= AXIS_X;
            end else if (cmd.mac) begin
                chunk_reg <= sts.chunk_last ? '0 : chunk_reg + CCW'(1);
            end else if (cmd.axis_store) begin
                axis_reg <= axis_reg + 2'd1;
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg    <= s_x_coord;
            y_reg    <= s_y_coord;
            z_reg    <= s_z_coord;
            last_reg <= s_last;
        end
        if (cmd.mac) begin
            acc_reg <= acc_base + AW'(mul_w);
        end
        if (cmd.axis_store) begin
            idx_reg[axis_reg] <= a_idx;
            oog_reg[axis_reg] <= a_oog;
        end
        if (cmd.commit) begin
            m_box_count_reg   <= count_next;
            m_new_box_reg     <= is_new;
            m_out_of_grid_reg <= |oog_reg;
            m_done_res_reg    <= last_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_box_count   = m_box_count_reg;
    assign m_new_box     = m_new_box_reg;
    assign m_out_of_grid = m_out_of_grid_reg;
    assign m_done_res    = m_done_res_reg;

endmodule

[hw/rtl/box_count_occupancy.sv]
// Top level of the box count occupancy block: controller, datapath and checks.
//
//  channel  | handshake            | word
//  ---------+----------------------+-----------------------------------------------
//  cfg      | cfg_valid/cfg_ready  | cfg_inv_scale
//  s (in)   | s_valid/s_ready      | s_x_coord s_y_coord s_z_coord s_start_req s_last
//  m (out)  | m_valid/m_ready      | m_box_count m_new_box m_out_of_grid m_done_res
//
// A point runs CH = ceil(COORD_WIDTH/16) chunks per axis through the one 16x32
// multiply-accumulate, then bitmap read and write. A start word adds one clear
// sweep of 2^(3*GRID_BITS-5) bitmap rows, one row per cycle (1024 rows at
// GRID_BITS 5); the same sweep runs after reset with s_ready low. cfg_ready is
// always high. A result waits in the output register; the next word is accepted
// meanwhile and stalls only at its bitmap write.
module box_count_occupancy #(
    parameter int GRID_BITS   = bco_pkg::GRID_BITS_DEF,
    parameter int COORD_WIDTH = bco_pkg::COORD_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bco_pkg::SCALE_W-1:0]      cfg_inv_scale,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [COORD_WIDTH-1:0]    s_x_coord,
    input  logic signed [COORD_WIDTH-1:0]    s_y_coord,
    input  logic signed [COORD_WIDTH-1:0]    s_z_coord,
    input  logic                             s_start_req,
    input  logic                             s_last,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [bco_pkg::COUNT_W-1:0]      m_box_count,
    output logic                             m_new_box,
    output logic                             m_out_of_grid,
    output logic                             m_done_res
);
    import bco_pkg::*;

    cmd_t    cmd;
    status_t sts;

    assign cfg_ready = 1'b1;

    bco_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_start_req (s_start_req),
        .s_ready     (s_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    bco_dp #(
        .GRID_BITS   (GRID_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_valid     (cfg_valid),
        .cfg_inv_scale (cfg_inv_scale),
        .s_x_coord     (s_x_coord),
        .s_y_coord     (s_y_coord),
        .s_z_coord     (s_z_coord),
        .s_start_req   (s_start_req),
        .s_last        (s_last),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_box_count   (m_box_count),
        .m_new_box     (m_new_box),
        .m_out_of_grid (m_out_of_grid),
        .m_done_res    (m_done_res)
    );

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_step |-> !s_ready)
        else $error("input ready during clear sweep");

    a_new_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_new_box) |-> (!m_out_of_grid && (m_box_count != '0)))
        else $error("new box result inconsistent");

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid || m_ready))
        else $error("result overwritten before taken");
`endif

endmodule

[verif/tb_top.sv]
// Self-checking testbench for box_count_occupancy: directed grid cases, then random point sets.
`timescale 1ns / 100ps

module tb_top;
    import bco_pkg::*;

    localparam int G           = GRID_BITS_DEF;
    localparam int COORD_W     = COORD_WIDTH_DEF;
    localparam int CELLS       = 1 << (3 * G);
    localparam int DRAIN_CYCLES = 40;
    // ~1300 words; worst case each waits an idle gap, a clear sweep and a receiver stall
    localparam int CYCLE_LIMIT = 6_000_000;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [COUNT_W-1:0] box_count;
        logic               new_box;
        logic               out_of_grid;
        logic               done_res;
    } box_result_t;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_BLOCKS} rx_mode_t;

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [SCALE_W-1:0]   cfg_inv_scale = '0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    coord_t               s_x_coord     = '0;
    coord_t               s_y_coord     = '0;
    coord_t               s_z_coord     = '0;
    logic                 s_start_req   = 1'b0;
    logic                 s_last        = 1'b0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [COUNT_W-1:0]   m_box_count;
    logic                 m_new_box;
    logic                 m_out_of_grid;
    logic                 m_done_res;

    // predictor state
    bit                   occ_map [CELLS];
    logic [COUNT_W-1:0]   running_boxes = '0;
    logic [SCALE_W-1:0]   scale_model   = INV_SCALE_RESET;
    box_result_t          box_results_due [$];

    rx_mode_t rx_mode     = RX_OPEN;
    bit       rx_stalled  = 1'b0;
    int       rx_left     = 0;
    bit       tx_idle_en  = 1'b1;
    int       burst_left  = 0;

    int fail_count     = 0;
    int cycle_count    = 0;
    int points_sent    = 0;
    int results_seen   = 0;
    int sets_closed    = 0;
    int new_boxes      = 0;
    int oog_points     = 0;
    int scale_writes   = 0;
    int peak_count     = 0;

    box_count_occupancy #(
        .GRID_BITS   (G),
        .COORD_WIDTH (COORD_W)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_inv_scale (cfg_inv_scale),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_x_coord     (s_x_coord),
        .s_y_coord     (s_y_coord),
        .s_z_coord     (s_z_coord),
        .s_start_req   (s_start_req),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_box_count   (m_box_count),
        .m_new_box     (m_new_box),
        .m_out_of_grid (m_out_of_grid),
        .m_done_res    (m_done_res)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still due", $time, box_results_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // box index of one axis; returns 0 when outside the grid
    function automatic logic axis_box(input coord_t c, input logic [SCALE_W-1:0] s,
                                      output logic [G-1:0] idx);
        logic [COORD_W+31:0] prod;
        logic [COORD_W-1:0]  q;
        idx = '0;
        if (s == '0)
            return 1'b1;
        if (c[COORD_W-1])
            return 1'b0;
        prod = {32'b0, c} * {{COORD_W{1'b0}}, s};
        q    = prod[COORD_W+31:32];
        if (q >= (1 << G))
            return 1'b0;
        idx = q[G-1:0];
        return 1'b1;
    endfunction

    task automatic predict_occupancy(input coord_t x, y, z, input logic st, lst);
        logic [G-1:0]   bi, bj, bk;
        logic           ok_i, ok_j, ok_k;
        logic [3*G-1:0] box_addr;
        box_result_t    r;
        if (st) begin
            occ_map       = '{default: 1'b0};
            running_boxes = '0;
        end
        ok_i = axis_box(x, scale_model, bi);
        ok_j = axis_box(y, scale_model, bj);
        ok_k = axis_box(z, scale_model, bk);
        r = '0;
        if (!(ok_i && ok_j && ok_k)) begin
            r.out_of_grid = 1'b1;
            oog_points++;
        end else begin
            box_addr = {bi, bj, bk};
            if (!occ_map[box_addr]) begin
                occ_map[box_addr] = 1'b1;
                r.new_box = 1'b1;
                new_boxes++;
                if (running_boxes != '1)
                    running_boxes++;
            end
        end
        r.box_count = running_boxes;
        r.done_res  = lst;
        if (lst)
            sets_closed++;
        box_results_due.push_back(r);
    endtask

    // result checker
    always @(posedge aclk) begin
        box_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_box_count > peak_count)
                peak_count = m_box_count;
            if (box_results_due.size() == 0) begin
                $display("%0t: unexpected result, count %0d", $time, m_box_count);
                fail_count++;
            end else begin
                want = box_results_due.pop_front();
                if (m_box_count !== want.box_count) begin
                    $display("%0t: box_count expected %0d got %0d", $time,
                             want.box_count, m_box_count);
                    fail_count++;
                end
                if (m_new_box !== want.new_box) begin
                    $display("%0t: new_box expected %0b got %0b", $time,
                             want.new_box, m_new_box);
                    fail_count++;
                end
                if (m_out_of_grid !== want.out_of_grid) begin
                    $display("%0t: out_of_grid expected %0b got %0b", $time,
                             want.out_of_grid, m_out_of_grid);
                    fail_count++;
                end
                if (m_done_res !== want.done_res) begin
                    $display("%0t: done_res expected %0b got %0b", $time,
                             want.done_res, m_done_res);
                    fail_count++;
                end
            end
        end
    end

    // receiver stall pattern
    always @(negedge aclk) begin
        case (rx_mode)
            RX_OPEN: begin
                m_ready <= 1'b1;
            end
            RX_RANDOM: begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (rx_left == 0) begin
                    rx_stalled = !rx_stalled;
                    rx_left    = rx_stalled ? $urandom_range(1, 16) : $urandom_range(1, 8);
                end
                rx_left--;
                m_ready <= !rx_stalled;
            end
        endcase
    end

    // entered just after a falling edge, returns just after one
    task automatic send_point(input coord_t x, y, z, input logic st, lst);
        if (tx_idle_en && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        s_valid     <= 1'b1;
        s_x_coord   <= x;
        s_y_coord   <= y;
        s_z_coord   <= z;
        s_start_req <= st;
        s_last      <= lst;
        do @(posedge aclk); while (!s_ready);
        predict_occupancy(x, y, z, st, lst);
        points_sent++;
        @(negedge aclk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] val);
        cfg_inv_scale <= val;
        cfg_valid     <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        scale_model = val;
        scale_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_block();
        s_valid <= 1'b0;
        while (box_results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // coordinate spread over 'span' of the grid's boxes per axis, plus edge and noise values
    function automatic coord_t pick_coord(input int span);
        logic [63:0] ext, region;
        if (scale_model == '0)
            return coord_t'($urandom);
        ext    = (64'd1 << (G + 32)) / scale_model;
        region = (ext * span) >> G;
        if (region == 0)
            region = 1;
        if (region > 64'h7FFF_FFFF)
            region = 64'h7FFF_FFFF;
        if (ext > 64'h7FFF_FFFF)
            ext = 64'h7FFF_FFFF;
        case ($urandom_range(0, 15))
            0:       return coord_t'($urandom);
            1:       return -coord_t'($urandom_range(1, 32'hFFFF));
            2:       return coord_t'(ext - 2 + $urandom_range(0, 4));
            default: return coord_t'($urandom_range(0, 32'(region - 1)));
        endcase
    endfunction

    // points arriving before any start land in the bitmap left by reset
    task automatic test_before_start();
        rx_mode    = RX_RANDOM;
        tx_idle_en = 1'b1;
        send_point(32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0);
        send_point(32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0);
        send_point(32'sh0001_0000, 32'sh0, 32'sh0, 1'b0, 1'b0);
        send_point(32'sh001F_FFFF, 32'sh001F_FFFF, 32'sh001F_FFFF, 1'b1, 1'b1);
    endtask

    task automatic test_grid_edges();
        send_point(32'sh0020_0000, 32'sh0, 32'sh0, 1'b1, 1'b0);
        send_point(-32'sh1, 32'sh0, 32'sh0, 1'b0, 1'b0);
        send_point(32'sh0, 32'sh8000_0000, 32'sh0, 1'b0, 1'b0);
        send_point(32'sh0, 32'sh0, 32'sh7FFF_FFFF, 1'b0, 1'b0);
        send_point(32'sh001F_FFFF, 32'sh0, 32'sh001F_0000, 1'b0, 1'b0);
        send_point(32'sh0000_FFFF, 32'sh0000_FFFF, 32'sh0000_FFFF, 1'b0, 1'b0);
        send_point(32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b1);
    endtask

    // zero scale puts every point, negative ones too, into box (0,0,0)
    task automatic test_zero_scale();
        drain_block();
        write_scale('0);
        rx_mode = RX_BLOCKS;
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh1, 1'b1, 1'b0);
        send_point(32'sh1234_5678, -32'sh0765_4321, 32'sh0, 1'b0, 1'b1);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 1'b0);
    endtask

    task automatic test_max_scale();
        drain_block();
        write_scale('1);
        send_point(32'sh1, 32'sh1, 32'sh1, 1'b1, 1'b0);
        send_point(32'sh20, 32'sh1F, 32'sh0, 1'b0, 1'b0);
        send_point(32'sh21, 32'sh0, 32'sh0, 1'b0, 1'b0);
        send_point(32'sh7FFF_FFFF, 32'sh0, 32'sh0, 1'b0, 1'b1);
    endtask

    task automatic test_min_scale();
        drain_block();
        write_scale(32'd1);
        rx_mode    = RX_OPEN;
        tx_idle_en = 1'b0;
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 1'b1);
        send_point(-32'sh1, 32'sh0, 32'sh0, 1'b0, 1'b0);
        send_point(32'sh4000_0000, 32'sh0, 32'sh1, 1'b1, 1'b1);
    endtask

    task automatic run_random_phase(input logic [SCALE_W-1:0] scale, input rx_mode_t rxm,
                                    input bit idle_on, input int point_quota);
        int  sent_here;
        int  len;
        int  span;
        bit  noise;
        drain_block();
        write_scale(scale);
        rx_mode    = rxm;
        tx_idle_en = idle_on;
        sent_here  = 0;
        while (sent_here < point_quota) begin
            noise = ($urandom_range(0, 99) < 15);
            if (noise) begin
                len = $urandom_range(1, 6);
                for (int n = 0; n < len; n++)
                    send_point(coord_t'($urandom), pick_coord(32), coord_t'($urandom),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                len  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 24);
                span = $urandom_range(1, 32);
                for (int n = 0; n < len; n++)
                    send_point(pick_coord(span), pick_coord(span), pick_coord(span),
                               n == 0, n == len - 1);
            end
            sent_here += len;
        end
    endtask

    task automatic test_random_sets();
        run_random_phase(INV_SCALE_RESET, RX_RANDOM, 1'b1, 250);
        run_random_phase($urandom_range(32'h4000, 32'h40000), RX_OPEN, 1'b0, 250);
        run_random_phase(32'h0010_0000, RX_BLOCKS, 1'b1, 250);
        run_random_phase($urandom, RX_RANDOM, 1'b1, 250);
        run_random_phase(32'h0000_0800, RX_BLOCKS, 1'b0, 250);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_before_start();
        test_grid_edges();
        test_zero_scale();
        test_max_scale();
        test_min_scale();
        test_random_sets();
        drain_block();
        $display("Ran %0d points in %0d closed sets under %0d scale writes, %0d results checked",
                 points_sent, sets_closed, scale_writes, results_seen);
        $display("Saw %0d new boxes, %0d off-grid points, peak set count %0d",
                 new_boxes, oog_points, peak_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
